// ===== hw/rtl/tdma_slot_gossip_allocator_unit_macros.svh =====
// assertion helpers for the slot allocator
`ifndef TDMA_SLOT_GOSSIP_ALLOCATOR_UNIT_MACROS_SVH
`define TDMA_SLOT_GOSSIP_ALLOCATOR_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TSGA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define TSGA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tsga_pkg.sv =====
package tsga_pkg;

  localparam int unsigned MAX_NEIGHBOURS_DEF = 16;
  localparam int unsigned FRAME_SLOTS_DEF    = 32;
  localparam int unsigned MAP_BITS_DEF       = 32;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned MAP_W  = 32;
  localparam int unsigned SLOT_W = 8;
  localparam int unsigned LIFE_W = 8;
  localparam int unsigned RAND_W = 16;

  localparam logic       CMD_HEARD = 1'b0;
  localparam logic       CMD_TICK  = 1'b1;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT   = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_NO_TX      = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SLOT_W-1:0] slot;
    logic [LIFE_W-1:0] life;
  } nbr_entry_t;

  // bits of a map kept by the block
  function automatic logic [MAP_W-1:0] map_mask(input int unsigned bits);
    logic [MAP_W-1:0] m;
    m = '0;
    for (int unsigned i = 0; i < MAP_W; i++) begin
      m[i] = (i < bits);
    end
    return m;
  endfunction

  function automatic logic [MAP_W-1:0] slot_bit(input logic [SLOT_W-1:0] s,
                                                input int unsigned bits);
    logic [MAP_W-1:0] b;
    b = '0;
    for (int unsigned i = 0; i < MAP_W; i++) begin
      b[i] = (s == SLOT_W'(i)) && (i < bits);
    end
    return b;
  endfunction

endpackage

// ===== hw/rtl/tdma_slot_gossip_allocator_unit.sv =====
// Slot allocator for a time-slotted frame. One command is taken when start is
// high and busy is low; busy then stays high until the single result has been
// shown for one cycle with out_valid high. The result cannot be held off, so
// the receiver must take it in that cycle. A received heartbeat walks the
// neighbour table memory one entry a cycle; a bad slot goes straight to the
// result. A tick that keeps its slot walks the table too; a tick that must
// pick a slot first runs two reciprocal-multiply remainder units, then probes
// at most min(MAX_NEIGHBOURS, FRAME_SLOTS - 1) slots one a cycle, then walks
// the table. The neighbour_ttl register may be written at any time the block
// is idle; its port is always ready.
`include "tdma_slot_gossip_allocator_unit_macros.svh"

module tdma_slot_gossip_allocator_unit #(
  parameter int unsigned MAX_NEIGHBOURS = tsga_pkg::MAX_NEIGHBOURS_DEF,
  parameter int unsigned FRAME_SLOTS    = tsga_pkg::FRAME_SLOTS_DEF,
  parameter int unsigned MAP_BITS       = tsga_pkg::MAP_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [tsga_pkg::ADDR_W-1:0] in_src_addr,
  input  logic [tsga_pkg::MAP_W-1:0]  in_rx_colmap,
  input  logic [tsga_pkg::MAP_W-1:0]  in_rx_nbrmap,
  input  logic [tsga_pkg::SLOT_W-1:0] in_rx_slot,
  input  logic [tsga_pkg::RAND_W-1:0] in_rand_tx,
  input  logic [tsga_pkg::RAND_W-1:0] in_rand_rx,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [tsga_pkg::MAP_W-1:0]  out_colmap,
  output logic [tsga_pkg::MAP_W-1:0]  out_nbrmap,
  output logic [tsga_pkg::SLOT_W-1:0] out_tx_slot,
  output logic [tsga_pkg::SLOT_W-1:0] out_rx_slot,
  output logic                        out_slot_changed,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tsga_pkg::LIFE_W-1:0] cfg_neighbour_ttl
);
  import tsga_pkg::*;

  localparam int unsigned TX_RANGE = (MAX_NEIGHBOURS < FRAME_SLOTS - 1) ?
                                     MAX_NEIGHBOURS : FRAME_SLOTS - 1;
  localparam int unsigned RX_RANGE = FRAME_SLOTS - 1;
  localparam int unsigned IW  = $clog2(MAX_NEIGHBOURS);
  localparam int unsigned CW  = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned TW  = $clog2(TX_RANGE + 1);
  localparam int unsigned TXW = $clog2(TX_RANGE) + 1;
  localparam int unsigned RXW = $clog2(RX_RANGE) + 1;
  localparam logic [MAP_W-1:0]  MASK = map_mask(MAP_BITS);
  localparam logic [SLOT_W-1:0] TXR8 = SLOT_W'(TX_RANGE);
  localparam logic [SLOT_W-1:0] RXR8 = SLOT_W'(RX_RANGE);
  localparam logic [SLOT_W-1:0] FS8  = SLOT_W'(FRAME_SLOTS);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_LOOKUP = 7'b0000010,
    S_UPDATE = 7'b0000100,
    S_DIVIDE = 7'b0001000,
    S_PROBE  = 7'b0010000,
    S_WALK   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // latched command
  logic               cmd_r;
  logic [ADDR_W-1:0]  src_r;
  logic [MAP_W-1:0]   colmap_r, nbrmap_r;
  logic [SLOT_W-1:0]  slot_r;

  // allocator state
  logic [LIFE_W-1:0]  ttl_r;
  logic [SLOT_W-1:0]  own_tx_r, own_tx_nxt;
  logic [SLOT_W-1:0]  own_rx_r, own_rx_nxt;
  logic               rx_chosen_r, rx_chosen_nxt;
  logic               col_seen_r, col_seen_nxt;
  logic [MAP_W-1:0]   occ_r, occ_nxt;
  logic [MAP_W-1:0]   pend_map_r, pend_map_nxt;

  // per-command working registers
  logic [1:0]         status_r, status_nxt;
  logic               changed_r, changed_nxt;
  logic [MAP_W-1:0]   pub_col_r, pub_col_nxt;
  logic [MAP_W-1:0]   pub_nbr_r, pub_nbr_nxt;
  logic [CW-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [IW-1:0]      pend_idx_r, pend_idx_nxt;
  logic               hit_r, hit_nxt;
  logic [IW-1:0]      hit_idx_r, hit_idx_nxt;
  logic               free_r, free_nxt;
  logic [IW-1:0]      free_idx_r, free_idx_nxt;
  logic [SLOT_W-1:0]  probe_s_r, probe_s_nxt;
  logic [TW-1:0]      tries_r, tries_nxt;

  // table memory ports
  logic               wr_en, rd_en;
  logic [IW-1:0]      wr_idx, rd_idx;
  nbr_entry_t         wr_data, rd_data;
  logic               rd_written;

  // remainder units
  logic               mod_start;
  logic               mod_tx_done, mod_rx_done;
  logic [TXW-1:0]     rem_tx;
  logic [RXW-1:0]     rem_rx;

  logic               accept;
  logic               live, addr_match;
  logic [MAP_W-1:0]   ent_bit;
  logic [SLOT_W-1:0]  inc, rx_s, rx_inc;
  logic               cand_free;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  tsga_nbr_mem #(.DEPTH(MAX_NEIGHBOURS)) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_idx     (wr_idx),
    .wr_data    (wr_data),
    .rd_en      (rd_en),
    .rd_idx     (rd_idx),
    .rd_data    (rd_data),
    .rd_written (rd_written)
  );

  tsga_mod #(.DIVISOR(TX_RANGE)) u_mod_tx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (in_rand_tx),
    .done  (mod_tx_done),
    .rem   (rem_tx)
  );

  tsga_mod #(.DIVISOR(RX_RANGE)) u_mod_rx (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .value (in_rand_rx),
    .done  (mod_rx_done),
    .rem   (rem_rx)
  );

  // entry under evaluation: its read was issued in the previous cycle
  assign live       = rd_written && (rd_data.life != '0);
  assign addr_match = live && (rd_data.addr == src_r);
  assign ent_bit    = slot_bit(rd_data.slot, MAP_BITS);

  // forward step of the tx search, wrapping within 1..TX_RANGE
  assign inc       = probe_s_r + 1'b1;
  assign cand_free = (probe_s_r != own_tx_r) &&
                     ((occ_r & slot_bit(probe_s_r, MAP_BITS)) == '0);

  // rx choice, moved two slots on, wrapping, if it lands on the new tx slot
  assign rx_s   = SLOT_W'(rem_rx) + 1'b1;
  assign rx_inc = rx_s + 1'b1;

  always_comb begin
    state_nxt     = state_r;
    own_tx_nxt    = own_tx_r;
    own_rx_nxt    = own_rx_r;
    rx_chosen_nxt = rx_chosen_r;
    col_seen_nxt  = col_seen_r;
    occ_nxt       = occ_r;
    pend_map_nxt  = pend_map_r;
    status_nxt    = status_r;
    changed_nxt   = changed_r;
    pub_col_nxt   = pub_col_r;
    pub_nbr_nxt   = pub_nbr_r;
    rd_cnt_nxt    = rd_cnt_r;
    pend_v_nxt    = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    probe_s_nxt   = probe_s_r;
    tries_nxt     = tries_r;
    mod_start     = 1'b0;
    rd_en         = 1'b0;
    rd_idx        = rd_cnt_r[IW-1:0];
    wr_en         = 1'b0;
    wr_idx        = pend_idx_r;
    wr_data       = rd_data;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt  = ST_OK;
          changed_nxt = 1'b0;
          pub_col_nxt = '0;
          pub_nbr_nxt = '0;
          rd_cnt_nxt  = '0;
          hit_nxt     = 1'b0;
          free_nxt    = 1'b0;
          if (in_cmd == CMD_HEARD) begin
            if (in_rx_slot == '0 || in_rx_slot >= FS8) begin
              status_nxt = ST_BAD_SLOT;
              state_nxt  = S_RESP;
            end else begin
              state_nxt = S_LOOKUP;
            end
          end else begin
            occ_nxt      = pend_map_r & MASK;
            pend_map_nxt = '0;
            if (own_tx_r == '0 || col_seen_r) begin
              mod_start = 1'b1;
              state_nxt = S_DIVIDE;
            end else begin
              pub_nbr_nxt = slot_bit(own_tx_r, MAP_BITS);
              state_nxt   = S_WALK;
            end
          end
        end
      end

      S_LOOKUP: begin
        if (rd_cnt_r != CW'(MAX_NEIGHBOURS)) begin
          rd_en        = 1'b1;
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = rd_cnt_r[IW-1:0];
        end
        if (pend_v_r) begin
          // first live match wins, else the last free entry
          if (!hit_r && addr_match) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = pend_idx_r;
          end
          if (!live) begin
            free_nxt     = 1'b1;
            free_idx_nxt = pend_idx_r;
          end
        end else if (rd_cnt_r == CW'(MAX_NEIGHBOURS)) begin
          if (hit_r || free_r) begin
            state_nxt = S_UPDATE;
          end else begin
            status_nxt = ST_TABLE_FULL;
            state_nxt  = S_RESP;
          end
        end
      end

      S_UPDATE: begin
        wr_en        = 1'b1;
        wr_idx       = hit_r ? hit_idx_r : free_idx_r;
        wr_data.addr = src_r;
        wr_data.slot = slot_r;
        wr_data.life = ttl_r;
        pend_map_nxt = (pend_map_r | nbrmap_r) & MASK;
        if ((colmap_r & slot_bit(own_tx_r, MAP_BITS)) != '0) begin
          col_seen_nxt = 1'b1;
        end
        state_nxt = S_RESP;
      end

      S_DIVIDE: begin
        if (mod_tx_done && mod_rx_done) begin
          probe_s_nxt = SLOT_W'(rem_tx) + 1'b1;
          tries_nxt   = '0;
          state_nxt   = S_PROBE;
        end
      end

      S_PROBE: begin
        if (cand_free) begin
          own_tx_nxt   = probe_s_r;
          changed_nxt  = 1'b1;
          col_seen_nxt = 1'b0;
          if (!rx_chosen_r) begin
            rx_chosen_nxt = 1'b1;
            if (rx_s == probe_s_r) begin
              own_rx_nxt = ((rx_inc >= RXR8) ? rx_inc - RXR8 : rx_inc) + 1'b1;
            end else begin
              own_rx_nxt = rx_s;
            end
          end
          pub_nbr_nxt = slot_bit(probe_s_r, MAP_BITS);
          state_nxt   = S_WALK;
        end else if (tries_r == TW'(TX_RANGE - 1)) begin
          status_nxt  = ST_NO_TX;
          pub_nbr_nxt = slot_bit(own_tx_r, MAP_BITS);
          state_nxt   = S_WALK;
        end else begin
          tries_nxt   = tries_r + 1'b1;
          probe_s_nxt = ((inc >= TXR8) ? inc - TXR8 : inc) + 1'b1;
        end
      end

      S_WALK: begin
        // read of entry i overlaps write-back of entry i-1, never the same entry
        if (rd_cnt_r != CW'(MAX_NEIGHBOURS)) begin
          rd_en        = 1'b1;
          rd_cnt_nxt   = rd_cnt_r + 1'b1;
          pend_v_nxt   = 1'b1;
          pend_idx_nxt = rd_cnt_r[IW-1:0];
        end
        if (pend_v_r) begin
          if (live) begin
            if ((pub_nbr_r & ent_bit) != '0) begin
              if (rd_data.slot == own_tx_r) begin
                col_seen_nxt = 1'b1;
              end
              pub_col_nxt = pub_col_r | ent_bit;
            end
            pub_nbr_nxt  = pub_nbr_r | ent_bit;
            wr_en        = 1'b1;
            wr_data.life = rd_data.life - 1'b1;
          end
        end else if (rd_cnt_r == CW'(MAX_NEIGHBOURS)) begin
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ttl_r       <= LIFE_W'(4);
      own_tx_r    <= '0;
      own_rx_r    <= '0;
      rx_chosen_r <= 1'b0;
      col_seen_r  <= 1'b0;
      occ_r       <= '0;
      pend_map_r  <= '0;
      pend_v_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      own_tx_r    <= own_tx_nxt;
      own_rx_r    <= own_rx_nxt;
      rx_chosen_r <= rx_chosen_nxt;
      col_seen_r  <= col_seen_nxt;
      occ_r       <= occ_nxt;
      pend_map_r  <= pend_map_nxt;
      pend_v_r    <= pend_v_nxt;
      if (cfg_valid && cfg_ready) begin
        ttl_r <= cfg_neighbour_ttl;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      src_r    <= in_src_addr;
      colmap_r <= in_rx_colmap;
      nbrmap_r <= in_rx_nbrmap;
      slot_r   <= in_rx_slot;
    end
    status_r   <= status_nxt;
    changed_r  <= changed_nxt;
    pub_col_r  <= pub_col_nxt;
    pub_nbr_r  <= pub_nbr_nxt;
    rd_cnt_r   <= rd_cnt_nxt;
    pend_idx_r <= pend_idx_nxt;
    hit_r      <= hit_nxt;
    hit_idx_r  <= hit_idx_nxt;
    free_r     <= free_nxt;
    free_idx_r <= free_idx_nxt;
    probe_s_r  <= probe_s_nxt;
    tries_r    <= tries_nxt;
  end

  // result stands for exactly the one cycle of the response state
  assign out_valid        = (state_r == S_RESP);
  assign out_status       = status_r;
  assign out_colmap       = (cmd_r == CMD_TICK) ? (pub_col_r & MASK) : '0;
  assign out_nbrmap       = (cmd_r == CMD_TICK) ? (pub_nbr_r & MASK) : '0;
  assign out_tx_slot      = own_tx_r;
  assign out_rx_slot      = own_rx_r;
  assign out_slot_changed = changed_r;

  `TSGA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid && !busy,
                    "result strobe held longer than one cycle")
  `TSGA_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
                    "command accepted but block not busy")
  `TSGA_ASSERT_SAME(a_tx_in_frame, out_valid, out_tx_slot < FS8,
                    "tx slot outside the frame")
  `TSGA_ASSERT_SAME(a_changed_has_tx, out_valid && out_slot_changed,
                    out_tx_slot != '0 && out_rx_slot != '0 && out_status == ST_OK,
                    "slot change reported without a tx and rx slot")
  `TSGA_ASSERT_SAME(a_mods_aligned, mod_tx_done, mod_rx_done,
                    "remainder units out of step")

endmodule

// ===== hw/rtl/tsga_nbr_mem.sv =====
module tsga_nbr_mem #(
  parameter int unsigned DEPTH = 16,
  localparam int unsigned IW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [IW-1:0]        wr_idx,
  input  tsga_pkg::nbr_entry_t wr_data,
  input  logic                 rd_en,
  input  logic [IW-1:0]        rd_idx,
  output tsga_pkg::nbr_entry_t rd_data,
  output logic                 rd_written
);
  import tsga_pkg::*;

  nbr_entry_t       mem [DEPTH];
  logic [DEPTH-1:0] written_r;
  nbr_entry_t       rd_data_r;
  logic             rd_written_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  // per-entry written flags stand in for the cleared life field
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_written_r <= written_r[rd_idx];
      end
    end
  end

  assign rd_data    = rd_data_r;
  assign rd_written = rd_written_r;

endmodule

// ===== hw/rtl/tsga_mod.sv =====
module tsga_mod #(
  parameter int unsigned DIVISOR = 31,
  localparam int unsigned RW = $clog2(DIVISOR) + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tsga_pkg::RAND_W-1:0] value,
  output logic                        done,
  output logic [RW-1:0]               rem
);
  import tsga_pkg::*;

  // reciprocal multiply gives the exact quotient for every RAND_W-bit value
  localparam int unsigned SH  = RAND_W + $clog2(DIVISOR);
  localparam int unsigned RCW = RAND_W + 1;
  localparam int unsigned PW  = 2 * RAND_W + 1;
  localparam logic [RCW-1:0] RECIP =
    RCW'(((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

  logic [PW-1:0]     prod;
  logic              stage_r;
  logic              done_r;
  logic [RAND_W-1:0] val_r;
  logic [RAND_W-1:0] quot_r;
  logic [RW-1:0]     rem_r;

  assign prod = PW'(value) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      stage_r <= start;
      done_r  <= stage_r;
    end
  end

  // quotient first, remainder from it in the next cycle
  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= value;
      quot_r <= RAND_W'(prod >> SH);
    end
    if (stage_r) begin
      rem_r <= RW'(val_r - RAND_W'(quot_r * RAND_W'(DIVISOR)));
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
